>>> src/hsv_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// Used by the front part, the back part, the top level and the testbench; depends on nothing.

package hsv_pkg;

	localparam int HUE_W   = 9;
	localparam int CHAN_W  = 8;
	localparam int FRAC_W  = 6;
	localparam int CFG_IDX_W = 1;

	// One sector of the hue circle, in degrees.
	localparam int SECTOR_DEG = 60;
	localparam int SECTORS    = 6;
	localparam int PEAK       = 255;
	// Common denominator of the q and t levels: 60 * 255.
	localparam int LEVEL_DEN  = SECTOR_DEG * PEAK;
	localparam int NUM_W      = 14;
	localparam int PROD_W     = NUM_W + CHAN_W;

	// Reciprocal of LEVEL_DEN scaled by 2^RECIP_SHIFT, rounded down.
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_MULT =
		RECIP_W'((64'd1 << RECIP_SHIFT) / LEVEL_DEN);

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 8;

	localparam logic [CHAN_W-1:0] SAT_RESET = 8'd255;
	localparam logic [CHAN_W-1:0] VAL_RESET = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 1'b0,
		REG_BRIGHTNESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
	} hsv_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

endpackage

>>> src/hsv_fifo.sv
// Small synchronous queue with registered storage and an occupancy count.
// Generic; used between the front and back parts and at the result side.

module hsv_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [Width-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [Width-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(Depth+1)-1:0] count
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/hsv_front.sv
// Front part: takes a hue, splits it into sector and fraction, holds it in one stage.
// Depends on hsv_pkg.

module hsv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [hsv_pkg::HUE_W-1:0]     hue,
	output logic                          full,
	output logic                          item_valid,
	output hsv_pkg::hsv_item_t            item,
	input  logic                          item_full
);

	logic                      valid_s1;
	hsv_pkg::hsv_item_t        item_s1;
	logic [3:0]                quot;
	logic [2:0]                sector_raw;
	logic [hsv_pkg::HUE_W-1:0] base;
	logic                      take;

	// Quotient by 60 of a 9-bit hue is at most 8: count the thresholds passed.
	always_comb begin
		quot = '0;
		for (int k = 1; k <= 8; k++) begin
			if (hue >= hsv_pkg::HUE_W'(k * hsv_pkg::SECTOR_DEG)) begin
				quot = quot + 1'b1;
			end
		end
		base       = hsv_pkg::HUE_W'(quot * hsv_pkg::SECTOR_DEG);
		sector_raw = (quot >= 4'(hsv_pkg::SECTORS)) ?
			3'(quot - 4'(hsv_pkg::SECTORS)) : quot[2:0];
	end

	assign full       = valid_s1 && item_full;
	assign take       = push && !full;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.sector <= hsv_pkg::sector_t'(sector_raw);
			item_s1.frac   <= hsv_pkg::FRAC_W'(hue - base);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

endmodule

>>> src/hsv_back.sv
// Back part: forms the p, q and t levels in a three-stage pipeline, routes them
// by sector and queues the colors. Depends on hsv_pkg and hsv_fifo.

module hsv_back #(
	parameter int OutDepth = hsv_pkg::OUT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  hsv_pkg::hsv_item_t         item,
	output logic                       item_pop,
	input  logic [hsv_pkg::CHAN_W-1:0] saturation,
	input  logic [hsv_pkg::CHAN_W-1:0] brightness,
	output hsv_pkg::rgb_t              rgb,
	output logic                       empty,
	input  logic                       pop
);

	localparam int CntW   = $clog2(OutDepth + 1);
	localparam int NumW   = hsv_pkg::NUM_W;
	localparam int ProdW  = hsv_pkg::PROD_W;
	localparam int ChanW  = hsv_pkg::CHAN_W;
	localparam int WideW  = ProdW + hsv_pkg::RECIP_W;

	logic [CntW-1:0]  out_count;
	logic [1:0]       inflight;

	// Stage 1: numerators.
	logic             valid_s1;
	hsv_pkg::sector_t sector_s1;
	logic [NumW-1:0]  num_q_s1;
	logic [NumW-1:0]  num_t_s1;
	logic [ChanW-1:0] num_p_s1;
	// Stage 2: products with the value.
	logic             valid_s2;
	hsv_pkg::sector_t sector_s2;
	logic [ProdW-1:0] prod_q_s2;
	logic [ProdW-1:0] prod_t_s2;
	logic [15:0]      prod_p_s2;
	// Stage 3: quotient estimates.
	logic             valid_s3;
	hsv_pkg::sector_t sector_s3;
	logic [ProdW-1:0] prod_q_s3;
	logic [ProdW-1:0] prod_t_s3;
	logic [ChanW-1:0] est_q_s3;
	logic [ChanW-1:0] est_t_s3;
	logic [ChanW-1:0] lvl_p_s3;

	logic [WideW-1:0] wide_q;
	logic [WideW-1:0] wide_t;
	logic [16:0]      div_p;
	logic [ProdW-1:0] rem_q;
	logic [ProdW-1:0] rem_t;
	logic [ChanW-1:0] lvl_q;
	logic [ChanW-1:0] lvl_t;
	hsv_pkg::rgb_t    color;

	// An item is issued only when the result queue has room for it and
	// for everything already in the pipeline.
	assign inflight = 2'(valid_s1) + 2'(valid_s2) + 2'(valid_s3);
	assign item_pop = item_valid &&
		((CntW + 1)'(out_count) + (CntW + 1)'(inflight) < (CntW + 1)'(OutDepth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= item_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= item.sector;
		num_q_s1  <= NumW'(hsv_pkg::LEVEL_DEN) - NumW'(item.frac * saturation);
		num_t_s1  <= NumW'(hsv_pkg::LEVEL_DEN)
			- NumW'((hsv_pkg::FRAC_W'(hsv_pkg::SECTOR_DEG) - item.frac) * saturation);
		num_p_s1  <= ChanW'(hsv_pkg::PEAK) - saturation;

		sector_s2 <= sector_s1;
		prod_q_s2 <= ProdW'(num_q_s1) * ProdW'(brightness);
		prod_t_s2 <= ProdW'(num_t_s1) * ProdW'(brightness);
		prod_p_s2 <= 16'(num_p_s1) * 16'(brightness);

		sector_s3 <= sector_s2;
		prod_q_s3 <= prod_q_s2;
		prod_t_s3 <= prod_t_s2;
		est_q_s3  <= ChanW'(wide_q >> hsv_pkg::RECIP_SHIFT);
		est_t_s3  <= ChanW'(wide_t >> hsv_pkg::RECIP_SHIFT);
		lvl_p_s3  <= ChanW'(div_p >> 8);
	end

	// The reciprocal estimate is low by at most one; the logic after stage 3
	// corrects it before the color is queued.
	// Division by 255 of a product of two 8-bit values is exact as (x + (x >> 8) + 1) >> 8.
	always_comb begin
		wide_q = WideW'(prod_q_s2) * WideW'(hsv_pkg::RECIP_MULT);
		wide_t = WideW'(prod_t_s2) * WideW'(hsv_pkg::RECIP_MULT);
		div_p  = 17'(prod_p_s2) + 17'(prod_p_s2 >> 8) + 17'd1;
	end

	always_comb begin
		rem_q = prod_q_s3 - ProdW'(est_q_s3) * ProdW'(hsv_pkg::LEVEL_DEN);
		rem_t = prod_t_s3 - ProdW'(est_t_s3) * ProdW'(hsv_pkg::LEVEL_DEN);
		lvl_q = (rem_q >= ProdW'(hsv_pkg::LEVEL_DEN)) ? est_q_s3 + 1'b1 : est_q_s3;
		lvl_t = (rem_t >= ProdW'(hsv_pkg::LEVEL_DEN)) ? est_t_s3 + 1'b1 : est_t_s3;

		unique case (sector_s3)
			hsv_pkg::SECTOR_0: color = '{red: brightness, green: lvl_t, blue: lvl_p_s3};
			hsv_pkg::SECTOR_1: color = '{red: lvl_q, green: brightness, blue: lvl_p_s3};
			hsv_pkg::SECTOR_2: color = '{red: lvl_p_s3, green: brightness, blue: lvl_t};
			hsv_pkg::SECTOR_3: color = '{red: lvl_p_s3, green: lvl_q, blue: brightness};
			hsv_pkg::SECTOR_4: color = '{red: lvl_t, green: lvl_p_s3, blue: brightness};
			hsv_pkg::SECTOR_5: color = '{red: brightness, green: lvl_p_s3, blue: lvl_q};
			default:           color = '{red: brightness, green: lvl_p_s3, blue: lvl_q};
		endcase
	end

	// The issue check keeps the result queue from overflowing, so its full
	// flag is not needed here.
	hsv_fifo #(
		.Width ($bits(hsv_pkg::rgb_t)),
		.Depth (OutDepth)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s3),
		.wdata  (color),
		.full   (),
		.pop    (pop),
		.rdata  (rgb),
		.empty  (empty),
		.count  (out_count)
	);

endmodule

>>> src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: configuration registers, front part,
// middle queue and back part. Depends on hsv_pkg, hsv_front, hsv_fifo, hsv_back.
//
// Usage. Hues enter through push/full: a hue transfers at a clock edge with
// push high and full low. Colors leave through empty/pop: while empty is low
// the oldest color is on red, green and blue, and it transfers at an edge with
// pop high. Saturation (register 0) and brightness (register 1) are written
// through cfg_we, cfg_index and cfg_data while no hue is in flight.
// A color is visible once its hue has passed the front stage, the middle queue,
// the three arithmetic stages and the result queue. Throughput: one hue per
// cycle while colors are popped, set by the three-stage multiplier pipeline.
// When the receiver stalls, up to OutDepth colors collect in the result queue;
// then the back part stops issuing, the middle queue and front stage fill,
// and full rises. Reset clears all queues and sets both registers to 255.

module hsv_to_rgb_converter #(
	parameter int MidDepth = hsv_pkg::MID_DEPTH,
	parameter int OutDepth = hsv_pkg::OUT_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [hsv_pkg::HUE_W-1:0]     hue,
	output logic                          empty,
	input  logic                          pop,
	output logic [hsv_pkg::CHAN_W-1:0]    red,
	output logic [hsv_pkg::CHAN_W-1:0]    green,
	output logic [hsv_pkg::CHAN_W-1:0]    blue,
	input  logic                          cfg_we,
	input  logic [hsv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hsv_pkg::CHAN_W-1:0]    cfg_data
);

	logic [hsv_pkg::CHAN_W-1:0] saturation_q;
	logic [hsv_pkg::CHAN_W-1:0] brightness_q;

	logic               front_valid;
	hsv_pkg::hsv_item_t front_item;
	logic               mid_full;
	logic               mid_empty;
	logic [$bits(hsv_pkg::hsv_item_t)-1:0] mid_rdata;
	logic               back_pop;
	hsv_pkg::rgb_t      color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q <= hsv_pkg::SAT_RESET;
			brightness_q <= hsv_pkg::VAL_RESET;
		end else if (cfg_we) begin
			unique case (hsv_pkg::cfg_reg_t'(cfg_index))
				hsv_pkg::REG_SATURATION: saturation_q <= cfg_data;
				hsv_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.hue        (hue),
		.full       (full),
		.item_valid (front_valid),
		.item       (front_item),
		.item_full  (mid_full)
	);

	hsv_fifo #(
		.Width ($bits(hsv_pkg::hsv_item_t)),
		.Depth (MidDepth)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.wdata  (front_item),
		.full   (mid_full),
		.pop    (back_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.count  ()
	);

	hsv_back #(
		.OutDepth (OutDepth)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item       (hsv_pkg::hsv_item_t'(mid_rdata)),
		.item_pop   (back_pop),
		.saturation (saturation_q),
		.brightness (brightness_q),
		.rgb        (color),
		.empty      (empty),
		.pop        (pop)
	);

	assign red   = color.red;
	assign green = color.green;
	assign blue  = color.blue;

endmodule

>>> test/hsv_to_rgb_converter_test.sv
// Testbench of the HSV to RGB converter: drives hues through the push/full side and
// checks every color that leaves through empty/pop against a predictor of its own.
// Depends on hsv_pkg and hsv_to_rgb_converter.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test;
	import hsv_pkg::*;

	// Holds the register copy and the colors still owed by the converter.
	class color_tracker;
		logic [CHAN_W-1:0] saturation = SAT_RESET;
		logic [CHAN_W-1:0] brightness = VAL_RESET;
		rgb_t pending_colors[$];
		int mismatches = 0;
		int hues_noted = 0;
		int colors_checked = 0;

		function void set_reg(cfg_reg_t idx, logic [CHAN_W-1:0] value);
			case (idx)
				REG_SATURATION: saturation = value;
				REG_BRIGHTNESS: brightness = value;
				default: ;
			endcase
		endfunction

		function rgb_t predict_color(logic [HUE_W-1:0] h);
			int unsigned hv, s, v, frac, p, q, t;
			int unsigned r, g, b;
			sector_t sector;
			rgb_t c;
			hv = h;
			s = saturation;
			v = brightness;
			sector = sector_t'((hv / SECTOR_DEG) % SECTORS);
			frac = hv % SECTOR_DEG;
			p = v * (PEAK - s) / PEAK;
			q = v * (LEVEL_DEN - frac * s) / LEVEL_DEN;
			t = v * (LEVEL_DEN - (SECTOR_DEG - frac) * s) / LEVEL_DEN;
			case (sector)
				SECTOR_0: begin r = v; g = t; b = p; end
				SECTOR_1: begin r = q; g = v; b = p; end
				SECTOR_2: begin r = p; g = v; b = t; end
				SECTOR_3: begin r = p; g = q; b = v; end
				SECTOR_4: begin r = t; g = p; b = v; end
				default:  begin r = v; g = p; b = q; end
			endcase
			c.red = CHAN_W'(r);
			c.green = CHAN_W'(g);
			c.blue = CHAN_W'(b);
			return c;
		endfunction

		task report(string what);
			$display("ERROR at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		function void note_hue(logic [HUE_W-1:0] h);
			pending_colors.push_back(predict_color(h));
			hues_noted++;
		endfunction

		task check_color(rgb_t got);
			rgb_t want;
			if (pending_colors.size() == 0) begin
				report($sformatf("color %0d/%0d/%0d with no hue waiting",
					got.red, got.green, got.blue));
			end else begin
				want = pending_colors.pop_front();
				colors_checked++;
				if (got.red !== want.red)
					report($sformatf("red %0d, predicted %0d", got.red, want.red));
				if (got.green !== want.green)
					report($sformatf("green %0d, predicted %0d", got.green, want.green));
				if (got.blue !== want.blue)
					report($sformatf("blue %0d, predicted %0d", got.blue, want.blue));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [HUE_W-1:0] hue;
	logic empty;
	logic pop;
	logic [CHAN_W-1:0] red, green, blue;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CHAN_W-1:0] cfg_data;

	color_tracker board = new();
	bit steady;
	int hold_request;
	int settings_used;

	hsv_to_rgb_converter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.hue(hue),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// A hue transfers at the first edge with push high and full low.
	task send_hue(input logic [HUE_W-1:0] h);
		while (!steady && $urandom_range(0, 99) < 13) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		hue <= h;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_hue(h);
	endtask

	task send_random_hues(input int count);
		logic [HUE_W-1:0] h;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				h = HUE_W'($urandom_range(384, 511));
			else
				h = HUE_W'($urandom_range(0, 383));
			send_hue(h);
		end
	endtask

	// Registers may only change once every color in flight has been taken.
	task drain;
		push <= 1'b0;
		while (board.pending_colors.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task set_levels(input logic [CHAN_W-1:0] sat, input logic [CHAN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= REG_SATURATION;
		cfg_data <= sat;
		@(posedge clk);
		cfg_index <= REG_BRIGHTNESS;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		board.set_reg(REG_SATURATION, sat);
		board.set_reg(REG_BRIGHTNESS, val);
		settings_used++;
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= steady || $urandom_range(0, 99) >= 13;
			end
			@(posedge clk);
			if (pop && !empty)
				board.check_color('{red, green, blue});
		end
	end

	initial begin
		logic [HUE_W-1:0] directed_hues[$];
		logic [CHAN_W-1:0] sat_list[$];
		logic [CHAN_W-1:0] val_list[$];
		arst_n = 1'b0;
		push = 1'b0;
		hue = '0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SATURATION;
		cfg_data = '0;
		steady = 1'b0;
		hold_request = 0;
		settings_used = 1;
		// Sector edges, wrap-around above 359, the top of the field and
		// alternating bit patterns.
		directed_hues = '{0, 1, 59, 60, 61, 119, 120, 179, 180, 239, 240, 299, 300,
			359, 360, 383, 384, 419, 420, 479, 480, 511, 170, 341, 256};
		sat_list = '{0, 255, 0, 255, 1, 128};
		val_list = '{255, 0, 0, 255, 1, 77};
		repeat (5) begin
			sat_list.push_back(CHAN_W'($urandom_range(0, 255)));
			val_list.push_back(CHAN_W'($urandom_range(0, 255)));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then the full directed set under saturation off.
		foreach (directed_hues[i])
			send_hue(directed_hues[i]);
		drain();
		set_levels(8'd0, 8'd255);
		foreach (directed_hues[i])
			send_hue(directed_hues[i]);
		drain();

		for (int k = 0; k < sat_list.size(); k++) begin
			set_levels(sat_list[k], val_list[k]);
			steady = (k == 2);
			// Long receiver stall while hues keep coming, so the input backs up.
			if (k == 4)
				hold_request = 60;
			send_random_hues(36);
			drain();
		end
		steady = 1'b0;

		if (board.pending_colors.size() != 0)
			board.report($sformatf("%0d colors never arrived", board.pending_colors.size()));
		$display("Sent %0d hues under %0d saturation/brightness settings;",
			board.hues_noted, settings_used);
		$display("%0d colors compared field by field, %0d errors.",
			board.colors_checked, board.mismatches);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
